FILE: hdl/olist_pkg.sv
package olist_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int LEN_W         = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Command broadcast to every cell of the row in the cycle a word is taken.
  typedef struct packed {
    logic              push_front;
    logic              push_back;
    logic              pop_front;
    logic              remove;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

FILE: hdl/olist_cell.sv
module olist_cell (
  input  logic                      clk,
  input  olist_pkg::cmd_t           cmd,
  input  logic [olist_pkg::DATA_W-1:0] left_data,
  input  logic [olist_pkg::DATA_W-1:0] right_data,
  input  logic                      live,
  input  logic                      tail_slot,
  input  logic                      found_in,
  output logic [olist_pkg::DATA_W-1:0] entry,
  output logic                      found_out
);
  import olist_pkg::*;

  logic match;

  // A cell at or after the first match takes its right neighbor's entry.
  assign match     = cmd.remove && live && (entry == cmd.value);
  assign found_out = found_in || match;

  always_ff @(posedge clk) begin
    priority if (cmd.push_front) begin
      entry <= left_data;
    end else if (cmd.push_back && tail_slot) begin
      entry <= cmd.value;
    end else if (cmd.pop_front || (cmd.remove && found_out)) begin
      entry <= right_data;
    end else begin
      entry <= entry;
    end
  end

endmodule

FILE: hdl/ordered_list_engine.sv
// Ordered list engine: a double-ended list of up to DEPTH signed 32-bit
// values, with removal of the first entry equal to a given value.
//
// A command word (op, value) is taken at a rising edge where start is high
// and busy is low. Busy stays low: every command finishes in the cycle it
// is taken, so one word per cycle is sustained. The result word
// (removed_value, status, length) appears in the cycle after the command and
// is marked by done for exactly one cycle; the receiver cannot stall it.
//
// The list lives in a row of DEPTH cells, one entry each. A push or pop at
// the front shifts the whole row one place; a push at the back writes only
// the cell after the last entry, and a pop at the back only shortens the
// length. A remove by value carries a found flag from the front cell to
// the back one, and every cell at or behind the first match takes its
// right neighbor's entry.
//
// Reset (rst, synchronous) empties the list and clears done. Entry
// contents are not cleared; only positions below the length are read.
module ordered_list_engine #(
  parameter int DEPTH = olist_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [olist_pkg::OP_W-1:0]     op,
  input  logic signed [olist_pkg::DATA_W-1:0] value,
  output logic                          busy,
  output logic                          done,
  output logic signed [olist_pkg::DATA_W-1:0] removed_value,
  output logic [olist_pkg::STATUS_W-1:0] status,
  output logic [olist_pkg::LEN_W-1:0]    length
);
  import olist_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                hit;
  cmd_t                cmd;
  logic [DATA_W-1:0]   back_value;
  logic [DATA_W-1:0]   removed_next;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_W-1:0]   entry [DEPTH];
  logic                found [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign hit    = found[DEPTH-1];

  // Entry at the back of the list, picked out by the length.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count == CW'(i + 1)) begin
        back_value = back_value | entry[i];
      end
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.value    = value;
    count_next   = count;
    removed_next = '0;
    status_next  = ST_OK;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.push_front = accept && (op == OP_PUSH_FRONT);
          cmd.push_back  = accept && (op == OP_PUSH_BACK);
          count_next     = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.pop_front = accept;
          removed_next  = entry[0];
          count_next    = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          removed_next = back_value;
          count_next   = count - 1'b1;
        end
      end
      OP_REMOVE: begin
        cmd.remove = accept;
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (hit) begin
          removed_next = value;
          count_next   = count - 1'b1;
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    olist_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  ((g == 0) ? value : entry[(g == 0) ? 0 : g - 1]),
      .right_data (entry[(g == DEPTH - 1) ? g : g + 1]),
      .live       (CW'(g) < count),
      .tail_slot  (count == CW'(g)),
      .found_in   ((g == 0) ? 1'b0 : found[(g == 0) ? 0 : g - 1]),
      .entry      (entry[g]),
      .found_out  (found[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= status_next;
      length        <= LEN_W'(count_next);
    end
  end

endmodule

FILE: tb/ordered_list_engine_tb.sv
`timescale 1ns / 100ps

module ordered_list_engine_tb;
  import olist_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_WORDS = 830;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  // Op codes that the block does not decode.
  localparam int OP_SPARE_FIRST = 5;
  localparam int OP_SPARE_LAST = 7;

  typedef struct {
    logic signed [DATA_W-1:0] removed_value;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0] length;
  } list_outcome_t;

  class list_tracker;
    int unsigned depth;
    logic signed [DATA_W-1:0] held_values[$];
    list_outcome_t pending_outcomes[$];
    int unsigned fail_count;

    function new(int unsigned list_depth);
      depth = list_depth;
      fail_count = 0;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    // Applies one accepted command word to the shadow list and queues the
    // outcome that the block should report for it.
    function void apply_command(logic [OP_W-1:0] cmd, logic signed [DATA_W-1:0] operand);
      list_outcome_t outcome;
      int n;
      int hit;
      outcome.removed_value = '0;
      outcome.status = ST_OK;
      hit = -1;
      case (cmd)
        OP_PUSH_FRONT: begin
          if (held_values.size() >= depth) outcome.status = ST_FULL;
          else held_values.push_front(operand);
        end
        OP_PUSH_BACK: begin
          if (held_values.size() >= depth) outcome.status = ST_FULL;
          else held_values.push_back(operand);
        end
        OP_POP_FRONT: begin
          if (held_values.size() == 0) outcome.status = ST_EMPTY;
          else outcome.removed_value = held_values.pop_front();
        end
        OP_POP_BACK: begin
          if (held_values.size() == 0) outcome.status = ST_EMPTY;
          else outcome.removed_value = held_values.pop_back();
        end
        OP_REMOVE: begin
          if (held_values.size() == 0) begin
            outcome.status = ST_EMPTY;
          end else begin
            foreach (held_values[i]) begin
              if (hit < 0 && held_values[i] == operand) hit = i;
            end
            if (hit < 0) begin
              outcome.status = ST_NOTFOUND;
            end else begin
              outcome.removed_value = operand;
              held_values.delete(hit);
            end
          end
        end
        default: ;
      endcase
      n = held_values.size();
      outcome.length = n[LEN_W-1:0];
      pending_outcomes.push_back(outcome);
    endfunction

    function void compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_outcome(logic signed [DATA_W-1:0] got_value,
                                logic [STATUS_W-1:0] got_status,
                                logic [LEN_W-1:0] got_length);
      list_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result word with no command waiting");
        fail_count++;
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("removed_value", want.removed_value, got_value);
      compare_field("status", DATA_W'(want.status), DATA_W'(got_status));
      compare_field("length", DATA_W'(want.length), DATA_W'(got_length));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic [OP_W-1:0] op;
  logic signed [DATA_W-1:0] value;
  logic busy;
  logic done;
  logic signed [DATA_W-1:0] removed_value;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0] length;
  int unsigned cycle_count;

  list_tracker tracker = new(LIST_DEPTH);

  ordered_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(op),
    .value(value),
    .busy(busy),
    .done(done),
    .removed_value(removed_value),
    .status(status),
    .length(length)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    op = '0;
    value = '0;
    cycle_count = 0;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The command is noted before the result is checked, so the order holds
  // even if a result were to come in the same cycle as its command.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.apply_command(op, value);
      if (done) tracker.check_outcome(removed_value, status, length);
    end
  end

  task automatic send_word(input logic [OP_W-1:0] cmd, input logic signed [DATA_W-1:0] operand);
    start <= 1'b1;
    op <= cmd;
    value <= operand;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic hold_off();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 93) idle_cycles($urandom_range(8, 40));
    else if (r >= 65) idle_cycles($urandom_range(1, 3));
  endtask

  // The first edge lets the monitor note the word accepted just before.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // A small pool of values makes duplicates and remove hits common.
  function automatic logic signed [DATA_W-1:0] pick_value(input int pool_percent);
    logic signed [DATA_W-1:0] v;
    if ($urandom_range(0, 99) >= pool_percent) return $urandom;
    case ($urandom_range(0, 7))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v = 32'sh0000_0000;
      3: v = -32'sd1;
      4: v = 32'sd1;
      5: v = 32'sh5555_5555;
      6: v = 32'shaaaa_aaaa;
      default: v = 32'sd42;
    endcase
    return v;
  endfunction

  task automatic random_word(input bit filling);
    int r;
    logic [OP_W-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 4) cmd = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else if (filling) begin
      if (r < 36) cmd = OP_PUSH_FRONT;
      else if (r < 70) cmd = OP_PUSH_BACK;
      else if (r < 78) cmd = OP_POP_FRONT;
      else if (r < 85) cmd = OP_POP_BACK;
      else cmd = OP_REMOVE;
    end else begin
      if (r < 12) cmd = OP_PUSH_FRONT;
      else if (r < 20) cmd = OP_PUSH_BACK;
      else if (r < 38) cmd = OP_POP_FRONT;
      else if (r < 55) cmd = OP_POP_BACK;
      else cmd = OP_REMOVE;
    end
    send_word(cmd, pick_value(cmd == OP_REMOVE ? 80 : 60));
  endtask

  initial begin
    int sent;
    int phase_len;
    bit filling;
    bit quiet;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Removals from an empty list, then the undecoded op codes.
    send_word(OP_POP_FRONT, 32'sd0);
    send_word(OP_POP_BACK, -32'sd1);
    send_word(OP_REMOVE, 32'sd7);
    for (int spare = OP_SPARE_FIRST; spare <= OP_SPARE_LAST; spare++) begin
      send_word(OP_W'(spare), 32'sh7fff_ffff);
    end
    send_word(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_word(OP_PUSH_BACK, 32'sh8000_0000);
    send_word(OP_PUSH_BACK, 32'sd5);
    send_word(OP_PUSH_FRONT, 32'sd5);
    // Only the first match is removed, here the one at the front.
    send_word(OP_REMOVE, 32'sd5);
    send_word(OP_PUSH_BACK, 32'sd0);
    send_word(OP_REMOVE, 32'sh8000_0000);
    send_word(OP_REMOVE, 32'sd99);
    send_word(OP_POP_BACK, 32'sd0);
    send_word(OP_POP_FRONT, 32'sd0);
    send_word(OP_POP_BACK, 32'sd0);
    send_word(OP_POP_FRONT, 32'sd0);
    wait_for_drain();

    sent = 0;
    filling = 1'b0;
    while (sent < RANDOM_WORDS) begin
      filling = !filling;
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        random_word(filling);
        sent++;
        if (!quiet) hold_off();
      end
      if ($urandom_range(0, 5) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/ordered_list_engine.sv
tb/ordered_list_engine_tb.sv
